FILE: hdl/kocc_pkg.sv
// ----------------------------------------------------------------------------
// kocc_pkg
// Shared types, keyword table and lookup function for the keyword counter.
// ----------------------------------------------------------------------------
package kocc_pkg;

  localparam int NumKeywords = 20;
  localparam int KwIdxW      = 5;
  localparam int HitW        = 16;
  localparam int KwMaxLen    = 8;

  // sorted keyword table, text right-justified in 64 bits
  localparam logic [63:0] KwText [NumKeywords] = '{
    64'("auto"),     64'("break"),  64'("case"),     64'("char"),
    64'("const"),    64'("continue"), 64'("default"), 64'("double"),
    64'("else"),     64'("float"),  64'("if"),       64'("int"),
    64'("long"),     64'("return"), 64'("struct"),   64'("switch"),
    64'("unsigned"), 64'("void"),   64'("volatile"), 64'("while")
  };

  localparam logic [3:0] KwLen [NumKeywords] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd6, 4'd4, 4'd5,
    4'd2, 4'd3, 4'd4, 4'd6, 4'd6, 4'd6, 4'd8, 4'd4, 4'd8, 4'd5
  };

  typedef struct packed {
    logic byte_en;
    logic load_pend;
    logic emit;
    logic clear;
  } kocc_cmd_t;

  typedef struct packed {
    logic out_free;
    logic final_entry;
  } kocc_sts_t;

  // character of keyword k at position p, zero past its end
  function automatic logic [7:0] kw_char(input logic [KwIdxW-1:0] k,
                                         input logic [2:0] p);
    logic [63:0] t;
    int          sh;
    t  = KwText[k];
    sh = 8 * (int'(KwLen[k]) - 1 - int'(p));
    if (sh < 0) begin
      return 8'd0;
    end
    return t[sh +: 8];
  endfunction

endpackage

FILE: hdl/keyword_occurrence_counter_core.sv
// ----------------------------------------------------------------------------
// keyword_occurrence_counter_core
// Counts whole-word occurrences of 20 C keywords in a byte stream.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while scanning; all 20 keywords are matched in
// parallel as the word is built. A byte with end_of_stream set starts the
// dump: in_stall_o stays high while the nonzero counters are snapshotted and
// then while one output word per entry is sent (n words for n nonzero
// keywords, or one empty-marker word), longer when out_stall_i holds the
// single output register. Counters clear at the end of the dump. No clearing
// pass is needed after reset.
module keyword_occurrence_counter_core #(
  parameter int MAX_WORD   = 100,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  char_byte_i,
  input  logic                        end_of_stream_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [kocc_pkg::KwIdxW-1:0] keyword_index_o,
  output logic [kocc_pkg::HitW-1:0]   hit_count_o,
  output logic                        entry_valid_o,
  output logic                        last_entry_o
);

  kocc_pkg::kocc_cmd_t cmd;
  kocc_pkg::kocc_sts_t sts;

  kocc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .end_of_stream_i (end_of_stream_i),
    .in_stall_o      (in_stall_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  kocc_datapath #(
    .MAX_WORD   (MAX_WORD),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .char_byte_i     (char_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .keyword_index_o (keyword_index_o),
    .hit_count_o     (hit_count_o),
    .entry_valid_o   (entry_valid_o),
    .last_entry_o    (last_entry_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i)
  );

endmodule

FILE: hdl/kocc_ctrl.sv
// ----------------------------------------------------------------------------
// kocc_ctrl
// Sequencer: scans bytes, then walks the count dump one entry per cycle while the output is free.
// ----------------------------------------------------------------------------
module kocc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                end_of_stream_i,
  output logic                in_stall_o,
  input  kocc_pkg::kocc_sts_t sts_i,
  output kocc_pkg::kocc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.byte_en = 1'b1;
          if (end_of_stream_i) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.load_pend = 1'b1;
        state_d         = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.final_entry) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/kocc_datapath.sv
// ----------------------------------------------------------------------------
// kocc_datapath
// Word tracker, parallel keyword match, saturating counters and dump output.
// ----------------------------------------------------------------------------
module kocc_datapath #(
  parameter int MAX_WORD   = 100,
  parameter int COUNT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  kocc_pkg::kocc_cmd_t                  cmd_i,
  output kocc_pkg::kocc_sts_t                  sts_o,
  input  logic [7:0]                           char_byte_i,
  input  logic                                 end_of_stream_i,
  output logic [kocc_pkg::KwIdxW-1:0]          keyword_index_o,
  output logic [kocc_pkg::HitW-1:0]            hit_count_o,
  output logic                                 entry_valid_o,
  output logic                                 last_entry_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i
);

  localparam int NumKw = kocc_pkg::NumKeywords;
  localparam int IdxW  = kocc_pkg::KwIdxW;
  localparam int HitW  = kocc_pkg::HitW;
  localparam int LenW  = $clog2(MAX_WORD);
  localparam int ExtW  = (COUNT_BITS > HitW) ? COUNT_BITS : HitW;
  localparam logic [LenW-1:0]       LenLast  = LenW'(MAX_WORD - 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [LenW-1:0]  len_q, len_d, cur_len, add_len, fin_len;
  logic             in_word_q, in_word_d, drop_q, drop_d;
  logic [NumKw-1:0] alive_q, alive_d, cur_alive, add_alive, fin_alive, kill;
  logic [NumKw-1:0] hit, nz, pend_q, pend_d;
  logic             fin, blank;
  logic [COUNT_BITS-1:0] cnt_q [NumKw];
  logic [COUNT_BITS-1:0] cnt_d [NumKw];
  logic [IdxW-1:0]  sel;
  logic [ExtW-1:0]  sel_cnt;
  logic             final_entry;

  logic [IdxW-1:0]  kidx_q;
  logic [HitW-1:0]  hitc_q;
  logic             evalid_q, elast_q, ovalid_q;

  // word tracking and match
  always_comb begin
    len_d     = len_q;
    in_word_d = in_word_q;
    drop_d    = drop_q;
    alive_d   = alive_q;
    fin       = 1'b0;
    fin_len   = len_q;
    fin_alive = alive_q;
    blank     = (char_byte_i == 8'd32) || (char_byte_i >= 8'd9 && char_byte_i <= 8'd13);
    cur_len   = in_word_q ? len_q : '0;
    cur_alive = in_word_q ? alive_q : '1;
    for (int k = 0; k < NumKw; k++) begin
      kill[k] = (cur_len >= LenW'(kocc_pkg::KwLen[k])) ||
                (kocc_pkg::kw_char(IdxW'(k), cur_len[2:0]) != char_byte_i);
    end
    add_alive = cur_alive & ~kill;
    add_len   = cur_len + LenW'(1);
    if (cmd_i.byte_en) begin
      if (drop_q) begin
        drop_d = 1'b0;
      end else if (blank) begin
        if (in_word_q) begin
          fin       = 1'b1;
          fin_len   = len_q;
          fin_alive = alive_q;
          in_word_d = 1'b0;
          len_d     = '0;
          alive_d   = '1;
        end
      end else if (add_len == LenLast) begin
        fin       = 1'b1;
        fin_len   = add_len;
        fin_alive = add_alive;
        in_word_d = 1'b0;
        len_d     = '0;
        alive_d   = '1;
        drop_d    = 1'b1;
      end else begin
        in_word_d = 1'b1;
        len_d     = add_len;
        alive_d   = add_alive;
      end
      if (end_of_stream_i) begin
        if (in_word_d) begin
          fin       = 1'b1;
          fin_len   = len_d;
          fin_alive = alive_d;
        end
        in_word_d = 1'b0;
        len_d     = '0;
        alive_d   = '1;
        drop_d    = 1'b0;
      end
    end
    for (int k = 0; k < NumKw; k++) begin
      hit[k] = fin && fin_alive[k] && (fin_len == LenW'(kocc_pkg::KwLen[k]));
    end
  end

  // saturating counters
  always_comb begin
    for (int k = 0; k < NumKw; k++) begin
      nz[k] = (cnt_q[k] != '0);
      if (cmd_i.clear) begin
        cnt_d[k] = '0;
      end else if (hit[k] && cnt_q[k] != CountMax) begin
        cnt_d[k] = cnt_q[k] + COUNT_BITS'(1);
      end else begin
        cnt_d[k] = cnt_q[k];
      end
    end
  end

  // dump walk over nonzero counters
  always_comb begin
    sel = '0;
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (pend_q[k]) begin
        sel = IdxW'(k);
      end
    end
    sel_cnt     = ExtW'(cnt_q[sel]);
    final_entry = ((pend_q & (pend_q - NumKw'(1))) == '0);
    pend_d      = pend_q;
    if (cmd_i.load_pend) begin
      pend_d = nz;
    end else if (cmd_i.emit) begin
      pend_d = pend_q & (pend_q - NumKw'(1));
    end
  end

  assign sts_o.out_free    = !ovalid_q || !out_stall_i;
  assign sts_o.final_entry = final_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      in_word_q <= 1'b0;
      drop_q    <= 1'b0;
      alive_q   <= '1;
      pend_q    <= '0;
      ovalid_q  <= 1'b0;
      for (int k = 0; k < NumKw; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      len_q     <= len_d;
      in_word_q <= in_word_d;
      drop_q    <= drop_d;
      alive_q   <= alive_d;
      pend_q    <= pend_d;
      for (int k = 0; k < NumKw; k++) begin
        cnt_q[k] <= cnt_d[k];
      end
      if (cmd_i.emit) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kidx_q   <= (pend_q != '0) ? sel : '0;
      hitc_q   <= (pend_q != '0) ? sel_cnt[HitW-1:0] : '0;
      evalid_q <= (pend_q != '0);
      elast_q  <= final_entry;
    end
  end

  assign keyword_index_o = kidx_q;
  assign hit_count_o     = hitc_q;
  assign entry_valid_o   = evalid_q;
  assign last_entry_o    = elast_q;
  assign out_valid_o     = ovalid_q;

  // each dumped entry retires exactly one pending keyword
  a_pend_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && pend_q != '0 |=>
      $countones(pend_q) == $countones($past(pend_q)) - 1)
    else $error("pending mask did not drop one keyword");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> nz == '0)
    else $error("counters not cleared after dump");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q < LenLast)
    else $error("word length past limit");

  a_idle_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_word_q |-> len_q == '0 && alive_q == '1)
    else $error("word state not reset between words");

endmodule

FILE: sim/tb_keyword_occurrence_counter_core.sv
// ----------------------------------------------------------------------------
// tb_keyword_occurrence_counter_core
// Self-checking bench for the keyword occurrence counter.
// ----------------------------------------------------------------------------
// Bytes go in through a valid/stall channel; an in-bench tally model follows
// every accepted byte and, on end of stream, queues the dump it should see.
// Each dump word that comes out is compared field by field with the oldest
// queued one. Directed text covers every keyword, near misses, odd bytes,
// an overlong word and the empty dump; random streams of keywords, damaged
// keywords and noise follow under several idle patterns.
// ----------------------------------------------------------------------------
module tb_keyword_occurrence_counter_core;

  typedef struct packed {
    logic [kocc_pkg::KwIdxW-1:0] idx;
    logic [kocc_pkg::HitW-1:0]   cnt;
    logic                        valid;
    logic                        last;
  } dump_word_t;

  class keyword_tally_board;
    string words [20] = '{
      "auto", "break", "case", "char", "const", "continue", "default",
      "double", "else", "float", "if", "int", "long", "return", "struct",
      "switch", "unsigned", "void", "volatile", "while"
    };
    bit [15:0]  tally [20];
    int         word_len;
    bit         in_word;
    bit         skip_byte;
    bit [19:0]  alive;
    dump_word_t expected_words [$];
    int         fail_count;

    function new();
      fail_count = 0;
      clear_tally();
    endfunction

    function void clear_tally();
      word_len  = 0;
      in_word   = 0;
      skip_byte = 0;
      alive     = '1;
      foreach (tally[k]) tally[k] = '0;
    endfunction

    function void close_word();
      for (int k = 0; k < 20; k++) begin
        if (alive[k] && words[k].len() == word_len && tally[k] != 16'hFFFF) begin
          tally[k]++;
        end
      end
      in_word  = 0;
      word_len = 0;
      alive    = '1;
    endfunction

    function void note_byte(logic [7:0] b, logic eos);
      dump_word_t w;
      int         n;
      if (skip_byte) begin
        skip_byte = 0;
      end else if (b == 8'd32 || (b >= 8'd9 && b <= 8'd13)) begin
        if (in_word) close_word();
      end else begin
        if (!in_word) begin
          in_word  = 1;
          word_len = 0;
          alive    = '1;
        end
        for (int k = 0; k < 20; k++) begin
          if (word_len >= words[k].len() || words[k][word_len] != b) alive[k] = 0;
        end
        word_len++;
        if (word_len >= 99) begin
          close_word();
          skip_byte = 1;
        end
      end
      if (!eos) return;
      if (in_word) close_word();
      n = 0;
      for (int k = 0; k < 20; k++) begin
        if (tally[k] != 0) begin
          w.idx   = k[kocc_pkg::KwIdxW-1:0];
          w.cnt   = tally[k];
          w.valid = 1'b1;
          w.last  = 1'b0;
          expected_words.push_back(w);
          n++;
        end
      end
      if (n == 0) begin
        w = '0;
        w.last = 1'b1;
        expected_words.push_back(w);
      end else begin
        expected_words[expected_words.size()-1].last = 1'b1;
      end
      clear_tally();
    endfunction

    function void flag(string what, dump_word_t exp_w, dump_word_t got_w);
      fail_count++;
      if (fail_count <= 10) begin
        $write("%s: expected idx %0d count %0d valid %0b last %0b, ",
               what, exp_w.idx, exp_w.cnt, exp_w.valid, exp_w.last);
        $display("got idx %0d count %0d valid %0b last %0b",
                 got_w.idx, got_w.cnt, got_w.valid, got_w.last);
      end
    endfunction

    function void check_word(dump_word_t got_w);
      dump_word_t exp_w;
      if (expected_words.size() == 0) begin
        flag("unexpected dump word", '0, got_w);
        return;
      end
      exp_w = expected_words.pop_front();
      if (got_w.idx !== exp_w.idx) flag("keyword_index mismatch", exp_w, got_w);
      if (got_w.cnt !== exp_w.cnt) flag("hit_count mismatch", exp_w, got_w);
      if (got_w.valid !== exp_w.valid) flag("entry_valid mismatch", exp_w, got_w);
      if (got_w.last !== exp_w.last) flag("last_entry mismatch", exp_w, got_w);
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [7:0]                  char_byte_i = '0;
  logic                        end_of_stream_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [kocc_pkg::KwIdxW-1:0] keyword_index_o;
  logic [kocc_pkg::HitW-1:0]   hit_count_o;
  logic                        entry_valid_o;
  logic                        last_entry_o;

  keyword_tally_board sb = new();
  int                 send_gap_pct = 0;
  int                 recv_stall_pct = 0;
  int                 phase_bytes;

  keyword_occurrence_counter_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_byte_i     (char_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .keyword_index_o (keyword_index_o),
    .hit_count_o     (hit_count_o),
    .entry_valid_o   (entry_valid_o),
    .last_entry_o    (last_entry_o)
  );

  always #5 clk_i = ~clk_i;

  // accepted bytes feed the tally model
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_byte(char_byte_i, end_of_stream_i);
  end

  // dump words are checked, receiver stalls at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word({keyword_index_o, hit_count_o, entry_valid_o, last_entry_o});
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    char_byte_i     <= b;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    phase_bytes++;
  endtask

  task automatic send_text(input string s, input logic eos);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eos && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] any_blank();
    logic [7:0] blanks [6] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};
    return blanks[$urandom_range(0, 5)];
  endfunction

  function automatic logic [7:0] any_word_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == 8'd32 || (b >= 8'd9 && b <= 8'd13));
    return b;
  endfunction

  // random stream of keywords, damaged keywords, long words and noise
  task automatic send_stream();
    logic [7:0] text [$];
    logic [7:0] wq [$];
    int         nwords;
    int         kind;
    int         k;
    int         i;
    nwords = $urandom_range(0, 8);
    for (int w = 0; w < nwords; w++) begin
      wq.delete();
      kind = $urandom_range(0, 99);
      k = $urandom_range(0, 19);
      for (int j = 0; j < sb.words[k].len(); j++) wq.push_back(sb.words[k][j]);
      if (kind >= 60 && kind < 78) begin
        i = $urandom_range(0, wq.size() - 1);
        case ($urandom_range(0, 3))
          0: wq[i] = wq[i] ^ 8'h20;
          1: void'(wq.pop_back());
          2: wq.push_back($urandom_range(0, 1) ? any_word_byte() : 8'h73);
          default: wq[i] = any_word_byte();
        endcase
      end else if (kind >= 78 && kind < 88) begin
        wq.delete();
        repeat ($urandom_range(1, 10)) wq.push_back(any_word_byte());
      end else if (kind >= 88 && kind < 93) begin
        repeat ($urandom_range(90, 105)) wq.push_back(any_word_byte());
      end else if (kind >= 93) begin
        wq.delete();
        wq.push_back(8'($urandom_range(0, 255)));
      end
      foreach (wq[j]) text.push_back(wq[j]);
      if (w < nwords - 1 || $urandom_range(0, 1)) begin
        repeat ($urandom_range(1, 3)) text.push_back(any_blank());
      end
    end
    if (text.size() == 0) text.push_back(any_blank());
    foreach (text[j]) send_byte(text[j], j == text.size() - 1);
  endtask

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed text
    send_gap_pct   = 28;
    recv_stall_pct = 28;
    send_text(" ", 1'b1);
    send_text("while", 1'b1);
    send_text("If int\tin\ninto\x0bdo\x0cdouble\rcases", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'd8, 1'b0);
    send_byte(8'd14, 1'b0);
    send_byte(8'd31, 1'b0);
    send_text(" if", 1'b0);
    send_byte(8'h00, 1'b0);
    send_text(" !if\x21 case", 1'b1);
    send_text("auto break case char const continue default double else float ", 1'b0);
    send_text("if int long return struct switch unsigned void volatile while", 1'b1);
    repeat (99) send_byte("c", 1'b0);
    send_text("void", 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 59; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 59; end
        default: begin send_gap_pct = 28; recv_stall_pct = 28; end
      endcase
      phase_bytes = 0;
      while (phase_bytes < 30) send_stream();
    end
    in_valid_i <= 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.expected_words.size() != 0) begin
      sb.flag("dump word never arrived", sb.expected_words[0], '0);
    end
    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/kocc_pkg.sv
hdl/kocc_ctrl.sv
hdl/kocc_datapath.sv
hdl/keyword_occurrence_counter_core.sv
sim/tb_keyword_occurrence_counter_core.sv
